// ===== rtl/msfd_pkg.sv =====
// Package: shared types and constants for the motor status frame deframer.
package msfd_pkg;

  // Frame markers
  localparam logic [7:0] HDR_BYTE0 = 8'hAA;
  localparam logic [7:0] HDR_BYTE1 = 8'h55;
  localparam logic [7:0] FTR_CR    = 8'h0D;
  localparam logic [7:0] FTR_LF    = 8'h0A;

  // Frame length counter and capture window
  localparam int LEN_W     = 5;
  localparam int CAP_DEPTH = 13;
  localparam int CAP_IDX_W = $clog2(CAP_DEPTH);
  localparam int CAP_FIRST = 2;  // first packet byte kept

  localparam logic [LEN_W-1:0] LEN_MAX       = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_HDR       = LEN_W'(CAP_FIRST);
  localparam logic [LEN_W-1:0] LEN_CAP_END   = LEN_W'(CAP_FIRST + CAP_DEPTH);
  localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = LEN_W'(8);

  // Data length is frame length minus the overhead bytes
  localparam int FRAME_OVERHEAD = 6;
  localparam logic [LEN_W-1:0] LEN_LEVEL1 = LEN_W'(FRAME_OVERHEAD + 4);
  localparam logic [LEN_W-1:0] LEN_LEVEL2 = LEN_W'(FRAME_OVERHEAD + 8);
  localparam logic [LEN_W-1:0] LEN_LEVEL3 = LEN_W'(FRAME_OVERHEAD + 12);

  // Data levels
  localparam logic [1:0] LVL_NONE  = 2'd0;
  localparam logic [1:0] LVL_SPEED = 2'd1;
  localparam logic [1:0] LVL_CURR  = 2'd2;
  localparam logic [1:0] LVL_TEMP  = 2'd3;

  // Result status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_SHORT = 1'b1;

  // Counters
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration registers
  localparam int MCNT_W = 9;
  localparam logic [MCNT_W-1:0] MCNT_RESET = MCNT_W'(1);
  localparam int PADDR_W = 3;
  localparam logic REG_MOTOR_COUNT = 1'b0;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SEEN_AA = 2'd1,
    PH_FRAME   = 2'd2
  } phase_t;

endpackage

// ===== rtl/motor_status_frame_deframer.sv =====
// Top level: byte-serial motor status frame parser with one result register.
//
//  channel   direction  handshake            payload
//  in_       sink       in_valid/in_ready    in_rx_byte
//  out_      source     out_valid/out_ready  status, id, level, fields, counters
//  cfg       APB slave  psel/penable/pready  motor_count at address 0
//
// One byte is taken per clock while in_ready is high; the parser state updates on the accepted beat.
// The footer byte decodes the frame from the capture registers, multiplies
// current by voltage and loads the result register in that same cycle.
// in_ready stays high while the result register is empty or being drained.
// rst_n is synchronous: phase, flags, length, counters and motor_count reset.
module motor_status_frame_deframer
  import msfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // byte input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_status,
  output logic [7:0]           out_motor_id,
  output logic                 out_id_in_range,
  output logic [1:0]           out_data_level,
  output logic signed [15:0]   out_speed,
  output logic signed [15:0]   out_angle,
  output logic signed [15:0]   out_current_raw,
  output logic signed [15:0]   out_voltage_raw,
  output logic signed [15:0]   out_temperature_raw,
  output logic signed [31:0]   out_power_raw,
  output logic [CNT_W-1:0]     out_good_frames,
  output logic [CNT_W-1:0]     out_bad_frames,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Parser state
  phase_t             phase_r, phase_nxt;
  logic               last_cr_r, last_cr_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [7:0]         cap_r [CAP_DEPTH];
  logic [CNT_W-1:0]   good_r, good_nxt;
  logic [CNT_W-1:0]   bad_r, bad_nxt;
  logic [MCNT_W-1:0]  mcnt_r;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic               status_r;
  logic [7:0]         id_r;
  logic               in_range_r;
  logic [1:0]         level_r;
  logic signed [15:0] speed_r, angle_r, curr_r, volt_r, temp_r;
  logic signed [31:0] power_r;
  logic [CNT_W-1:0]   good_out_r, bad_out_r;

  logic               in_fire;
  logic               emit;
  logic               cap_we;
  logic [CAP_IDX_W-1:0] cap_idx;
  logic [LEN_W-1:0]   len_inc;

  // Frame decode
  logic               short_frame;
  logic [1:0]         level;
  logic signed [15:0] w_speed, w_angle, w_curr, w_volt, w_temp;
  logic signed [31:0] w_power;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign len_inc  = (len_r < LEN_MAX) ? len_r + LEN_W'(1) : len_r;
  assign cap_idx  = CAP_IDX_W'(len_r - LEN_HDR);

  // Next state of the parser
  always_comb begin
    phase_nxt   = phase_r;
    last_cr_nxt = last_cr_r;
    len_nxt     = len_r;
    emit        = 1'b0;
    cap_we      = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_FRAME: begin
          cap_we      = (len_r >= LEN_HDR) && (len_r < LEN_CAP_END);
          len_nxt     = len_inc;
          last_cr_nxt = (in_rx_byte == FTR_CR);
          if (last_cr_r && (in_rx_byte == FTR_LF)) begin
            emit        = 1'b1;
            phase_nxt   = PH_HUNT;
            last_cr_nxt = 1'b0;
            len_nxt     = '0;
          end
        end
        PH_SEEN_AA: begin
          if (in_rx_byte == HDR_BYTE1) begin
            phase_nxt   = PH_FRAME;
            len_nxt     = LEN_HDR;
            last_cr_nxt = 1'b0;
          end else if (in_rx_byte != HDR_BYTE0) begin
            phase_nxt = PH_HUNT;
          end
        end
        default: begin
          phase_nxt = (in_rx_byte == HDR_BYTE0) ? PH_SEEN_AA : PH_HUNT;
        end
      endcase
    end
  end

  // Field decode at the footer; the footer and CR bytes never reach the result
  always_comb begin
    short_frame = (len_inc < MIN_FRAME_BYTES);
    if (len_inc >= LEN_LEVEL3)      level = LVL_TEMP;
    else if (len_inc >= LEN_LEVEL2) level = LVL_CURR;
    else if (len_inc >= LEN_LEVEL1) level = LVL_SPEED;
    else                            level = LVL_NONE;
    w_speed = $signed({cap_r[2],  cap_r[1]});
    w_angle = $signed({cap_r[4],  cap_r[3]});
    w_curr  = $signed({cap_r[6],  cap_r[5]});
    w_volt  = $signed({cap_r[8],  cap_r[7]});
    w_temp  = $signed({cap_r[10], cap_r[9]});
    w_power = w_curr * w_volt;
  end

  // Saturating frame counters
  always_comb begin
    good_nxt = good_r;
    bad_nxt  = bad_r;
    if (emit) begin
      if (short_frame) begin
        if (bad_r != CNT_MAX) bad_nxt = bad_r + CNT_W'(1);
      end else begin
        if (good_r != CNT_MAX) good_nxt = good_r + CNT_W'(1);
      end
    end
  end

  // Result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      last_cr_r   <= 1'b0;
      len_r       <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      last_cr_r   <= last_cr_nxt;
      len_r       <= len_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture registers for packet bytes 2 to 14
  always_ff @(posedge clk) begin
    if (cap_we) cap_r[cap_idx] <= in_rx_byte;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      good_out_r <= good_nxt;
      bad_out_r  <= bad_nxt;
      if (short_frame) begin
        status_r   <= ST_SHORT;
        id_r       <= '0;
        in_range_r <= 1'b0;
        level_r    <= LVL_NONE;
        speed_r    <= '0;
        angle_r    <= '0;
        curr_r     <= '0;
        volt_r     <= '0;
        temp_r     <= '0;
        power_r    <= '0;
      end else begin
        status_r   <= ST_OK;
        id_r       <= cap_r[0];
        in_range_r <= ({1'b0, cap_r[0]} < mcnt_r);
        level_r    <= level;
        speed_r    <= (level >= LVL_SPEED) ? w_speed : '0;
        angle_r    <= (level >= LVL_SPEED) ? w_angle : '0;
        curr_r     <= (level >= LVL_CURR)  ? w_curr  : '0;
        volt_r     <= (level >= LVL_CURR)  ? w_volt  : '0;
        temp_r     <= (level >= LVL_TEMP)  ? w_temp  : '0;
        power_r    <= (level >= LVL_TEMP)  ? w_power : '0;
      end
    end
  end

  // APB register: motor_count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= MCNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MOTOR_COUNT) begin
      mcnt_r <= pwdata[MCNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MOTOR_COUNT) ? {{(32-MCNT_W){1'b0}}, mcnt_r} : '0;

  // Outputs
  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_motor_id        = id_r;
  assign out_id_in_range     = in_range_r;
  assign out_data_level      = level_r;
  assign out_speed           = speed_r;
  assign out_angle           = angle_r;
  assign out_current_raw     = curr_r;
  assign out_voltage_raw     = volt_r;
  assign out_temperature_raw = temp_r;
  assign out_power_raw       = power_r;
  assign out_good_frames     = good_out_r;
  assign out_bad_frames      = bad_out_r;

endmodule
